[hw/rtl/pcsd_pkg.sv]
// ----------------------------------------------------------------------------
// pcsd_pkg: shared types and constants
// Command codes, parser phases, display memory geometry and the structs
// that pass between the decoder modules.
// ----------------------------------------------------------------------------
package pcsd_pkg;

	localparam int LED_BANK_COUNT     = 6;
	localparam int CONTROLLER_COLUMNS = 64;
	localparam int TILE_BYTES         = 8;

	localparam int WORDS_PER_PAGE = CONTROLLER_COLUMNS / 8;
	localparam int MEM_WORDS      = 2 * 8 * WORDS_PER_PAGE;
	localparam int MEM_AW         = $clog2(MEM_WORDS);
	localparam int WORD_W         = 8 * TILE_BYTES;
	localparam int BANK_W         = (LED_BANK_COUNT > 1) ? $clog2(LED_BANK_COUNT) : 1;
	localparam int TILE_CNT_W     = $clog2(TILE_BYTES);

	localparam logic [7:0] FIRST_LED_CMD = 8'h20;
	localparam logic [7:0] TILE_CMD_LO   = 8'h10;
	localparam logic [7:0] TILE_CMD_HI   = 8'h1F;
	localparam logic [7:0] BANK_OFF_VAL  = 8'hFF;
	localparam logic [7:0] COL_LIMIT     = 8'(CONTROLLER_COLUMNS);
	localparam logic [8:0] LED_CMD_END   = 9'(FIRST_LED_CMD) + 9'(LED_BANK_COUNT);

	typedef enum logic [1:0] {
		CMD_STREAM   = 2'd0,
		CMD_RD_BYTE  = 2'd1,
		CMD_RD_PIXEL = 2'd2,
		CMD_RD_LED   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_COLUMN  = 2'd1,
		PH_PAYLOAD = 2'd2,
		PH_LED_ARG = 2'd3
	} phase_t;

	typedef struct packed {
		logic        we;
		logic [MEM_AW-1:0] addr;
		logic [WORD_W-1:0] data;
	} dmem_wr_t;

	typedef struct packed {
		logic        tile_done;
		logic        led_done;
		logic [31:0] bytes;
		logic [31:0] tiles;
		logic [31:0] leds;
	} parse_stat_t;

	typedef struct packed {
		logic [7:0] data;
		logic       written;
	} led_query_t;

	function automatic logic is_led_cmd(input logic [7:0] b);
		return (b >= FIRST_LED_CMD) && ({1'b0, b} < LED_CMD_END);
	endfunction

	function automatic logic is_tile_start(input logic [7:0] b);
		return (b >= TILE_CMD_LO) && (b <= TILE_CMD_HI);
	endfunction

	// half/page nibble and column group to word address
	function automatic logic [MEM_AW-1:0] word_addr(input logic [3:0] half_page,
			input logic [2:0] grp);
		return MEM_AW'(MEM_AW'(half_page) * MEM_AW'(WORDS_PER_PAGE)) + MEM_AW'(grp);
	endfunction

endpackage

[hw/rtl/pcsd_req_if.sv]
// ----------------------------------------------------------------------------
// pcsd_req_if: request channel
// Valid/ready channel carrying one command beat with its query fields.
// ----------------------------------------------------------------------------
interface pcsd_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] data_byte;
	logic       half;
	logic [2:0] page;
	logic [5:0] column;
	logic [6:0] pixel_x;
	logic [5:0] pixel_y;
	logic [7:0] led_command;

	modport source(output valid, command, data_byte, half, page, column, pixel_x,
		pixel_y, led_command, input ready);
	modport sink(input valid, command, data_byte, half, page, column, pixel_x,
		pixel_y, led_command, output ready);
endinterface

[hw/rtl/pcsd_rsp_if.sv]
// ----------------------------------------------------------------------------
// pcsd_rsp_if: response channel
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
interface pcsd_rsp_if;
	logic        valid;
	logic        ready;
	logic [7:0]  read_data;
	logic        pixel_lit;
	logic        bank_written;
	logic        tile_committed;
	logic        led_updated;
	logic [31:0] bytes_seen;
	logic [31:0] tiles_written;
	logic [31:0] led_commands_done;

	modport source(output valid, read_data, pixel_lit, bank_written, tile_committed,
		led_updated, bytes_seen, tiles_written, led_commands_done, input ready);
	modport sink(input valid, read_data, pixel_lit, bank_written, tile_committed,
		led_updated, bytes_seen, tiles_written, led_commands_done, output ready);
endinterface

[hw/rtl/pcsd_dmem.sv]
// ----------------------------------------------------------------------------
// pcsd_dmem: display memory
// One write port, one registered read port. Per-word valid flops make
// unwritten words read as zero right after reset.
// ----------------------------------------------------------------------------
module pcsd_dmem (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pcsd_pkg::dmem_wr_t                wr,
	input  logic                              re,
	input  logic [pcsd_pkg::MEM_AW-1:0]       raddr,
	output logic [pcsd_pkg::WORD_W-1:0]       rdata
);

	logic [pcsd_pkg::WORD_W-1:0]    mem [pcsd_pkg::MEM_WORDS];
	logic [pcsd_pkg::MEM_WORDS-1:0] vld_q;
	logic [pcsd_pkg::WORD_W-1:0]    rdata_q;
	logic                           rvld_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (wr.we) begin
				vld_q[wr.addr] <= 1'b1;
			end
			if (re) begin
				rvld_q <= vld_q[raddr];
			end
		end
	end

	assign rdata = rvld_q ? rdata_q : '0;

endmodule

[hw/rtl/pcsd_parser.sv]
// ----------------------------------------------------------------------------
// pcsd_parser: stream byte decoder
// Phase FSM, tile assembly, LED banks and the three wrapping counters.
// ----------------------------------------------------------------------------
module pcsd_parser (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [7:0]             data_byte,
	input  logic [7:0]             led_command,
	output pcsd_pkg::parse_stat_t  stat,
	output pcsd_pkg::led_query_t   led_q,
	output pcsd_pkg::dmem_wr_t     wr
);

	pcsd_pkg::phase_t                   phase_q, phase_d;
	logic [3:0]                         target_q;
	logic [2:0]                         base_grp_q;
	logic [pcsd_pkg::TILE_CNT_W-1:0]    cnt_q;
	logic [pcsd_pkg::WORD_W-1:0]        payload_q;
	logic [pcsd_pkg::BANK_W-1:0]        bank_q;
	logic [7:0]                         led_bank_q [pcsd_pkg::LED_BANK_COUNT];
	logic [pcsd_pkg::LED_BANK_COUNT-1:0] mark_q;
	logic [31:0]                        bytes_q, tiles_q, leds_q;

	logic tile_start, led_cmd, col_ok, last_byte;
	logic load_target, load_bank, load_base, load_payload, tile_done, led_done;
	logic [pcsd_pkg::WORD_W-1:0] word_d;
	logic [7:0] bank_off, query_off;

	assign tile_start = pcsd_pkg::is_tile_start(data_byte);
	assign led_cmd    = pcsd_pkg::is_led_cmd(data_byte);
	assign col_ok     = (data_byte[2:0] == 3'b000) && (data_byte < pcsd_pkg::COL_LIMIT);
	assign last_byte  = (cnt_q == pcsd_pkg::TILE_CNT_W'(pcsd_pkg::TILE_BYTES - 1));
	assign bank_off   = data_byte - pcsd_pkg::FIRST_LED_CMD;
	assign query_off  = led_command - pcsd_pkg::FIRST_LED_CMD;

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (step) begin
			case (phase_q)
				pcsd_pkg::PH_IDLE: begin
					if (tile_start) phase_d = pcsd_pkg::PH_COLUMN;
					else if (led_cmd) phase_d = pcsd_pkg::PH_LED_ARG;
				end
				pcsd_pkg::PH_COLUMN: begin
					// bad column byte is decoded again as an idle byte
					if (col_ok) phase_d = pcsd_pkg::PH_PAYLOAD;
					else if (tile_start) phase_d = pcsd_pkg::PH_COLUMN;
					else if (led_cmd) phase_d = pcsd_pkg::PH_LED_ARG;
					else phase_d = pcsd_pkg::PH_IDLE;
				end
				pcsd_pkg::PH_PAYLOAD: begin
					if (last_byte) phase_d = pcsd_pkg::PH_IDLE;
				end
				pcsd_pkg::PH_LED_ARG: begin
					phase_d = pcsd_pkg::PH_IDLE;
				end
				default: phase_d = pcsd_pkg::PH_IDLE;
			endcase
		end
	end

	// actions
	always_comb begin
		load_target  = 1'b0;
		load_bank    = 1'b0;
		load_base    = 1'b0;
		load_payload = 1'b0;
		tile_done    = 1'b0;
		led_done     = 1'b0;
		if (step) begin
			case (phase_q)
				pcsd_pkg::PH_IDLE: begin
					load_target = tile_start;
					load_bank   = !tile_start && led_cmd;
				end
				pcsd_pkg::PH_COLUMN: begin
					load_base   = col_ok;
					load_target = !col_ok && tile_start;
					load_bank   = !col_ok && !tile_start && led_cmd;
				end
				pcsd_pkg::PH_PAYLOAD: begin
					load_payload = 1'b1;
					tile_done    = last_byte;
				end
				pcsd_pkg::PH_LED_ARG: begin
					led_done = 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		word_d = payload_q;
		word_d[{cnt_q, 3'b000} +: 8] = data_byte;
	end

	assign wr.we   = tile_done;
	assign wr.addr = pcsd_pkg::word_addr(target_q, base_grp_q);
	assign wr.data = word_d;

	assign stat.tile_done = tile_done;
	assign stat.led_done  = led_done;
	assign stat.bytes     = bytes_q + 32'(step);
	assign stat.tiles     = tiles_q + 32'(tile_done);
	assign stat.leds      = leds_q + 32'(led_done);

	always_comb begin
		if (pcsd_pkg::is_led_cmd(led_command)) begin
			led_q.data    = led_bank_q[pcsd_pkg::BANK_W'(query_off)];
			led_q.written = mark_q[pcsd_pkg::BANK_W'(query_off)];
		end else begin
			led_q.data    = pcsd_pkg::BANK_OFF_VAL;
			led_q.written = 1'b0;
		end
	end

	// payload bytes need no reset
	always_ff @(posedge clk) begin
		if (load_payload) begin
			payload_q <= word_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= pcsd_pkg::PH_IDLE;
			target_q   <= '0;
			base_grp_q <= '0;
			cnt_q      <= '0;
			bank_q     <= '0;
			mark_q     <= '0;
			bytes_q    <= '0;
			tiles_q    <= '0;
			leds_q     <= '0;
			for (int i = 0; i < pcsd_pkg::LED_BANK_COUNT; i++) begin
				led_bank_q[i] <= pcsd_pkg::BANK_OFF_VAL;
			end
		end else begin
			phase_q <= phase_d;
			if (load_target) target_q <= data_byte[3:0];
			if (load_bank) bank_q <= pcsd_pkg::BANK_W'(bank_off);
			if (load_base) begin
				base_grp_q <= data_byte[5:3];
				cnt_q      <= '0;
			end
			if (load_payload) cnt_q <= last_byte ? '0 : cnt_q + 1'b1;
			if (led_done) begin
				led_bank_q[bank_q] <= data_byte;
				mark_q[bank_q]     <= 1'b1;
			end
			bytes_q <= stat.bytes;
			tiles_q <= stat.tiles;
			leds_q  <= stat.leds;
		end
	end

endmodule

[hw/rtl/panel_command_stream_decoder.sv]
// ----------------------------------------------------------------------------
// panel_command_stream_decoder: host-to-panel stream decoder, top level
// Decodes tile and LED commands into display memory and LED banks and
// answers display byte, pixel and LED bank queries.
// ----------------------------------------------------------------------------
// One beat on req gives one beat on rsp, in order. The block takes a beat
// every cycle unless stage 1 is full and the output register stalls; a
// beat enters stage 1 at acceptance, where stream bytes update the parser
// and queries issue their display memory read, whose data is registered
// alongside stage 1, and the result goes to the rsp output register; req
// stays ready while the output register holds a beat as long as stage 1 is
// empty or moves on. Display memory is a 128 x 64 synchronous RAM with one
// write and one read port; each tile commit writes one aligned word, so a
// query right after a commit already sees the new data. No clearing pass is
// needed after reset: per-word valid bits make unwritten words read as zero.
module panel_command_stream_decoder (
	input  logic      clk,
	input  logic      arst_n,
	pcsd_req_if.sink  req,
	pcsd_rsp_if.source rsp
);

	// handshake
	logic in_fire, out_free, s1_adv;
	logic s1_v_q, rsp_v_q;

	// stage 1 (beat accepted, memory read in flight)
	pcsd_pkg::cmd_t        cmd_s1;
	logic [2:0]            col_lo_s1;
	logic [2:0]            bit_s1;
	logic                  oob_s1;
	pcsd_pkg::led_query_t  led_s1;
	pcsd_pkg::parse_stat_t stat_s1;

	// output register
	logic [7:0]            rd_q;
	logic                  lit_q, bw_q;
	pcsd_pkg::parse_stat_t stat_q;

	pcsd_pkg::cmd_t        cmd;
	pcsd_pkg::parse_stat_t stat;
	pcsd_pkg::led_query_t  led_q;
	pcsd_pkg::led_query_t  led_in;
	pcsd_pkg::dmem_wr_t    wr;
	logic                  step, re;
	logic [pcsd_pkg::MEM_AW-1:0] raddr;
	logic [pcsd_pkg::WORD_W-1:0] mem_rdata;
	logic [5:0]            q_col;
	logic [3:0]            q_half_page;
	logic                  q_oob;
	logic [7:0]            byte_s1;
	logic [7:0]            rd_d;
	logic                  lit_d;

	assign out_free  = !rsp_v_q || rsp.ready;
	assign req.ready = !s1_v_q || out_free;
	assign in_fire   = req.valid && req.ready;
	assign s1_adv    = s1_v_q && out_free;

	assign cmd  = pcsd_pkg::cmd_t'(req.command);
	assign step = in_fire && (cmd == pcsd_pkg::CMD_STREAM);

	// query address: byte read uses half/page/column, pixel read splits x/y
	always_comb begin
		if (cmd == pcsd_pkg::CMD_RD_PIXEL) begin
			q_col       = req.pixel_x[5:0];
			q_half_page = {req.pixel_x[6], req.pixel_y[5:3]};
		end else begin
			q_col       = req.column;
			q_half_page = {req.half, req.page};
		end
	end

	// columns past the controller width read as zero
	assign q_oob = ({2'b00, q_col} >= pcsd_pkg::COL_LIMIT);
	assign raddr = pcsd_pkg::word_addr(q_half_page, q_col[5:3]);
	assign re    = in_fire && ((cmd == pcsd_pkg::CMD_RD_BYTE) || (cmd == pcsd_pkg::CMD_RD_PIXEL));

	pcsd_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.data_byte   (req.data_byte),
		.led_command (req.led_command),
		.stat        (stat),
		.led_q       (led_q),
		.wr          (wr)
	);

	pcsd_dmem u_dmem (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.re     (re),
		.raddr  (raddr),
		.rdata  (mem_rdata)
	);

	// written flag only answers LED bank queries
	assign led_in.data    = led_q.data;
	assign led_in.written = led_q.written && (cmd == pcsd_pkg::CMD_RD_LED);

	// result assembly from memory word
	assign byte_s1 = mem_rdata[{col_lo_s1, 3'b000} +: 8];

	always_comb begin
		rd_d  = 8'h00;
		lit_d = 1'b0;
		case (cmd_s1)
			pcsd_pkg::CMD_RD_BYTE:  rd_d  = oob_s1 ? 8'h00 : byte_s1;
			pcsd_pkg::CMD_RD_PIXEL: lit_d = !oob_s1 && byte_s1[bit_s1];
			pcsd_pkg::CMD_RD_LED:   rd_d  = led_s1.data;
			default: ;
		endcase
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_s1    <= cmd;
			col_lo_s1 <= q_col[2:0];
			bit_s1    <= req.pixel_y[2:0];
			oob_s1    <= q_oob;
			led_s1    <= led_in;
			stat_s1   <= stat;
		end
		if (s1_adv) begin
			rd_q   <= rd_d;
			lit_q  <= lit_d;
			bw_q   <= led_s1.written;
			stat_q <= stat_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			rsp_v_q <= 1'b0;
		end else begin
			if (in_fire) s1_v_q <= 1'b1;
			else if (s1_adv) s1_v_q <= 1'b0;
			if (s1_adv) rsp_v_q <= 1'b1;
			else if (rsp.ready) rsp_v_q <= 1'b0;
		end
	end

	assign rsp.valid             = rsp_v_q;
	assign rsp.read_data         = rd_q;
	assign rsp.pixel_lit         = lit_q;
	assign rsp.bank_written      = bw_q;
	assign rsp.tile_committed    = stat_q.tile_done;
	assign rsp.led_updated       = stat_q.led_done;
	assign rsp.bytes_seen        = stat_q.bytes;
	assign rsp.tiles_written     = stat_q.tiles;
	assign rsp.led_commands_done = stat_q.leds;

	// stage 1 full and output stalled: no new beat may enter
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_v_q && rsp_v_q && !rsp.ready) |-> !req.ready)
		else $error("req accepted while pipeline full");

	// memory is written only by an accepted stream beat that ends a tile
	a_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		wr.we |-> (step && stat.tile_done))
		else $error("display memory write without tile commit");

	// a beat cannot both commit a tile and store an LED argument
	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_v_q |-> !(stat_q.tile_done && stat_q.led_done))
		else $error("tile commit and LED update on one beat");

	// a query beat leaves the stream byte counter unchanged
	a_query_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (cmd != pcsd_pkg::CMD_STREAM)) |=> (stat_s1.bytes == $past(stat.bytes)))
		else $error("query changed byte counter");

endmodule

[tb/pcsd_tb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsd_tb_pkg: beat types and scoreboard for the panel decoder bench
// Holds a behavioral copy of the parser, display memory and LED banks,
// predicts one response per accepted request and checks responses in order.
// ----------------------------------------------------------------------------
package pcsd_tb_pkg;
	import pcsd_pkg::*;

	typedef struct {
		cmd_t       command;
		logic [7:0] data_byte;
		logic       half;
		logic [2:0] page;
		logic [5:0] column;
		logic [6:0] pixel_x;
		logic [5:0] pixel_y;
		logic [7:0] led_command;
	} panel_req_t;

	typedef struct {
		logic [7:0]  read_data;
		logic        pixel_lit;
		logic        bank_written;
		logic        tile_committed;
		logic        led_updated;
		logic [31:0] bytes_seen;
		logic [31:0] tiles_written;
		logic [31:0] led_commands_done;
	} panel_rsp_t;

	class panel_scoreboard;
		phase_t      phase;
		logic [3:0]  tile_target;
		logic [5:0]  base_col;
		int unsigned payload_cnt;
		logic [63:0] payload;
		logic [3:0]  pending_bank;
		logic [63:0] dmem [MEM_WORDS];
		logic [7:0]  led_val [LED_BANK_COUNT];
		logic        led_mark [LED_BANK_COUNT];
		logic [31:0] byte_cnt, tile_cnt, led_cnt;
		panel_rsp_t  expected_q[$];
		int unsigned mismatches;
		int unsigned results_checked;

		function new();
			phase = PH_IDLE;
			tile_target = '0;
			base_col = '0;
			payload_cnt = 0;
			payload = '0;
			pending_bank = '0;
			foreach (dmem[i]) dmem[i] = '0;
			foreach (led_val[i]) begin
				led_val[i] = BANK_OFF_VAL;
				led_mark[i] = 1'b0;
			end
			byte_cnt = '0;
			tile_cnt = '0;
			led_cnt = '0;
			mismatches = 0;
			results_checked = 0;
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		function logic [7:0] display_byte(logic half, logic [2:0] page, logic [5:0] col);
			int idx;
			if (col >= CONTROLLER_COLUMNS)
				return 8'h00;
			idx = (int'(half) * 8 + int'(page)) * WORDS_PER_PAGE + int'(col) / 8;
			return dmem[idx][(int'(col) % 8) * 8 +: 8];
		endfunction

		// idle decode: tile start or LED command opens a sequence, anything else drops
		function void idle_byte(logic [7:0] b);
			if (b >= TILE_CMD_LO && b <= TILE_CMD_HI) begin
				tile_target = b[3:0];
				phase = PH_COLUMN;
			end else if (b >= FIRST_LED_CMD && int'(b) < int'(FIRST_LED_CMD) + LED_BANK_COUNT) begin
				pending_bank = 4'(b - FIRST_LED_CMD);
				phase = PH_LED_ARG;
			end
		endfunction

		function void stream_byte(logic [7:0] b, output logic tile_done, output logic led_done);
			int idx;
			tile_done = 1'b0;
			led_done = 1'b0;
			case (phase)
				PH_IDLE: idle_byte(b);
				PH_COLUMN: begin
					if (b[2:0] == 3'd0 && b < CONTROLLER_COLUMNS) begin
						base_col = b[5:0];
						payload_cnt = 0;
						payload = '0;
						phase = PH_PAYLOAD;
					end else begin
						// bad column: back to idle and decode the same byte again
						phase = PH_IDLE;
						idle_byte(b);
					end
				end
				PH_PAYLOAD: begin
					payload[payload_cnt * 8 +: 8] = b;
					payload_cnt++;
					if (payload_cnt >= TILE_BYTES) begin
						idx = int'(tile_target) * WORDS_PER_PAGE + int'(base_col) / 8;
						dmem[idx] = payload;
						payload_cnt = 0;
						phase = PH_IDLE;
						tile_cnt++;
						tile_done = 1'b1;
					end
				end
				default: begin
					if (pending_bank < LED_BANK_COUNT) begin
						led_val[pending_bank] = b;
						led_mark[pending_bank] = 1'b1;
					end
					phase = PH_IDLE;
					led_cnt++;
					led_done = 1'b1;
				end
			endcase
		endfunction

		function void note_request(panel_req_t r);
			panel_rsp_t e;
			logic [7:0] pix_byte;
			e = '{default: '0};
			case (r.command)
				CMD_STREAM: begin
					byte_cnt++;
					stream_byte(r.data_byte, e.tile_committed, e.led_updated);
				end
				CMD_RD_BYTE: e.read_data = display_byte(r.half, r.page, r.column);
				CMD_RD_PIXEL: begin
					pix_byte = display_byte(r.pixel_x[6], r.pixel_y[5:3], r.pixel_x[5:0]);
					e.pixel_lit = pix_byte[r.pixel_y[2:0]];
				end
				default: begin
					if (r.led_command >= FIRST_LED_CMD &&
							int'(r.led_command) < int'(FIRST_LED_CMD) + LED_BANK_COUNT) begin
						e.read_data = led_val[r.led_command - FIRST_LED_CMD];
						e.bank_written = led_mark[r.led_command - FIRST_LED_CMD];
					end else begin
						e.read_data = BANK_OFF_VAL;
					end
				end
			endcase
			e.bytes_seen = byte_cnt;
			e.tiles_written = tile_cnt;
			e.led_commands_done = led_cnt;
			expected_q.push_back(e);
		endfunction

		function bit field_ok(string name, logic [31:0] want, logic [31:0] got);
			if (got === want)
				return 1'b1;
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
			return 1'b0;
		endfunction

		function void check_result(panel_rsp_t got);
			panel_rsp_t e;
			bit ok;
			if (expected_q.size() == 0) begin
				$display("%0t: response beat with nothing expected, read_data 0x%0h",
					$time, got.read_data);
				mismatches++;
				return;
			end
			e = expected_q.pop_front();
			results_checked++;
			ok = 1'b1;
			ok &= field_ok("read_data", e.read_data, got.read_data);
			ok &= field_ok("pixel_lit", e.pixel_lit, got.pixel_lit);
			ok &= field_ok("bank_written", e.bank_written, got.bank_written);
			ok &= field_ok("tile_committed", e.tile_committed, got.tile_committed);
			ok &= field_ok("led_updated", e.led_updated, got.led_updated);
			ok &= field_ok("bytes_seen", e.bytes_seen, got.bytes_seen);
			ok &= field_ok("tiles_written", e.tiles_written, got.tiles_written);
			ok &= field_ok("led_commands_done", e.led_commands_done, got.led_commands_done);
			if (!ok)
				mismatches++;
		endfunction
	endclass

endpackage

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: bench for panel_command_stream_decoder
// Drives request beats with random gaps, back-pressures the response side at
// random and checks every response against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_top;
	import pcsd_pkg::*;
	import pcsd_tb_pkg::*;

	localparam int RANDOM_ITEMS = 700;

	logic clk = 1'b0;
	logic arst_n;

	pcsd_req_if req();
	pcsd_rsp_if rsp();

	panel_command_stream_decoder i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	panel_scoreboard sb = new();

	int unsigned items_sent;
	int unsigned req_quiet, rsp_quiet;  // remaining beats of a no-gap stretch
	bit          mix_queries;           // drop queries between stream bytes
	logic [3:0]  last_target;           // most recent tile, steers queries at it
	logic [5:0]  last_col;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop; a correct run with worst-case gaps and stalls needs well under 1 ms.
	initial begin
		#(64'd3_000_000);
		$display("FAILURE");
		$finish;
	end

	// Wait per beat: mostly a uniformly random gap, with the odd stretch of back-to-back beats.
	function automatic int unsigned pick_wait(inout int unsigned quiet);
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			quiet = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 17);
	endfunction

	// All fields random, so unused fields toggle every bit too.
	function automatic panel_req_t any_fields();
		panel_req_t r;
		r.command = cmd_t'($urandom_range(0, 3));
		r.data_byte = 8'($urandom);
		r.half = 1'($urandom);
		r.page = 3'($urandom);
		r.column = 6'($urandom);
		r.pixel_x = 7'($urandom);
		r.pixel_y = 6'($urandom);
		r.led_command = 8'($urandom);
		return r;
	endfunction

	// Query beat; half of them aimed at the tile written last.
	function automatic panel_req_t random_query();
		panel_req_t r;
		r = any_fields();
		r.command = cmd_t'($urandom_range(1, 3));
		if ($urandom_range(0, 1)) begin
			r.half = last_target[3];
			r.page = last_target[2:0];
			r.column = last_col + 6'($urandom_range(0, 7));
			r.pixel_x = {last_target[3], last_col + 6'($urandom_range(0, 7))};
			r.pixel_y = {last_target[2:0], 3'($urandom)};
		end
		if ($urandom_range(0, 9) < 8)
			r.led_command = FIRST_LED_CMD - 8'd2 + 8'($urandom_range(0, 9));
		return r;
	endfunction

	// One request beat: gap with valid low, then hold valid until ready.
	task automatic send_item(input panel_req_t r);
		int unsigned gap;
		gap = pick_wait(req_quiet);
		@(negedge clk);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.valid <= 1'b1;
		req.command <= r.command;
		req.data_byte <= r.data_byte;
		req.half <= r.half;
		req.page <= r.page;
		req.column <= r.column;
		req.pixel_x <= r.pixel_x;
		req.pixel_y <= r.pixel_y;
		req.led_command <= r.led_command;
		forever begin
			@(posedge clk);
			if (req.ready === 1'b1)
				break;
		end
		sb.note_request(r);
		items_sent++;
	endtask

	task automatic stream(input logic [7:0] b);
		panel_req_t r;
		if (mix_queries && $urandom_range(0, 9) == 0)
			send_item(random_query());
		r = any_fields();
		r.command = CMD_STREAM;
		r.data_byte = b;
		send_item(r);
	endtask

	// Byte and pixel queries share coordinates: x[6] half, x[5:0] column, y[5:3] page.
	task automatic ask(input cmd_t c, input logic [6:0] x, input logic [5:0] y,
			input logic [7:0] code);
		panel_req_t r;
		r = any_fields();
		r.command = c;
		r.half = x[6];
		r.column = x[5:0];
		r.page = y[5:3];
		r.pixel_x = x;
		r.pixel_y = y;
		r.led_command = code;
		send_item(r);
	endtask

	task automatic send_tile(input logic [3:0] tgt, input logic [5:0] col);
		stream(TILE_CMD_LO | 8'(tgt));
		stream(8'(col));
		repeat (TILE_BYTES) stream(8'($urandom));
		last_target = tgt;
		last_col = col;
	endtask

	// Response side: random stall per beat, check on each accepted beat.
	initial begin
		panel_rsp_t got;
		int unsigned stall;
		rsp.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = pick_wait(rsp_quiet);
			@(negedge clk);
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp.ready <= 1'b1;
			forever begin
				@(posedge clk);
				if (rsp.valid === 1'b1)
					break;
			end
			got.read_data = rsp.read_data;
			got.pixel_lit = rsp.pixel_lit;
			got.bank_written = rsp.bank_written;
			got.tile_committed = rsp.tile_committed;
			got.led_updated = rsp.led_updated;
			got.bytes_seen = rsp.bytes_seen;
			got.tiles_written = rsp.tiles_written;
			got.led_commands_done = rsp.led_commands_done;
			sb.check_result(got);
		end
	end

	initial begin
		int unsigned pick, drain;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.command = CMD_STREAM;
		req.data_byte = '0;
		req.half = 1'b0;
		req.page = '0;
		req.column = '0;
		req.pixel_x = '0;
		req.pixel_y = '0;
		req.led_command = '0;
		items_sent = 0;
		req_quiet = 0;
		rsp_quiet = 0;
		mix_queries = 1'b0;
		last_target = '0;
		last_col = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// --- directed ---
		ask(CMD_RD_BYTE, 7'h7F, 6'h3F, 8'h00);        // unwritten memory reads zero
		ask(CMD_RD_LED, 7'h00, 6'h00, FIRST_LED_CMD); // bank off, never written
		stream(8'hFF);                                // idle noise, ignored
		// tile at the far corner: upper controller, page 7, last column group
		stream(TILE_CMD_HI);
		stream(8'h38);
		stream(8'hFF); stream(8'h00); stream(8'h01); stream(8'h80);
		stream(8'hAA); stream(8'h55); stream(8'h7F); stream(8'hFE);
		ask(CMD_RD_BYTE, 7'h7F, 6'h3F, 8'h00);        // 0xFE
		ask(CMD_RD_PIXEL, 7'h7F, 6'h3F, 8'h00);       // bottom pixel of 0xFE, lit
		ask(CMD_RD_PIXEL, 7'h79, 6'h38, 8'h00);       // top pixel of 0x00, dark
		// bad column that is itself an LED command: re-decoded as one
		stream(TILE_CMD_LO);
		stream(FIRST_LED_CMD + 8'd3);
		stream(8'h5A);
		// column past the controller, then column not on a group boundary
		stream(TILE_CMD_LO + 8'd4);
		stream(8'h40);
		stream(TILE_CMD_LO + 8'd2);
		stream(8'h0C);
		// last bank, then reads of a written bank and of codes outside the range
		stream(FIRST_LED_CMD + 8'(LED_BANK_COUNT - 1));
		stream(8'h00);
		ask(CMD_RD_LED, 7'h00, 6'h00, FIRST_LED_CMD + 8'(LED_BANK_COUNT - 1));
		ask(CMD_RD_LED, 7'h00, 6'h00, FIRST_LED_CMD + 8'(LED_BANK_COUNT));
		ask(CMD_RD_LED, 7'h00, 6'h00, 8'hFF);

		// --- random: mostly well-formed tile and LED sequences ---
		mix_queries = 1'b1;
		drain = items_sent + RANDOM_ITEMS;
		while (items_sent < drain) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				send_tile(4'($urandom), 6'($urandom_range(0, 7) * 8));
			end else if (pick < 55) begin
				stream(FIRST_LED_CMD + 8'($urandom_range(0, LED_BANK_COUNT - 1)));
				stream(8'($urandom));
			end else if (pick < 85) begin
				send_item(random_query());
			end else if (pick < 95) begin
				// broken tile: start byte then whatever comes
				stream(TILE_CMD_LO | 8'($urandom_range(0, 15)));
				stream(8'($urandom));
			end else begin
				stream(8'($urandom));
			end
		end

		@(negedge clk);
		req.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		// let the pipe drain; give stray beats a chance to show up
		repeat (10) @(posedge clk);

		$display("Run covered %0d request beats and %0d checked responses.",
			items_sent, sb.results_checked);
		$display("Stream: %0d bytes, %0d tiles committed, %0d LED commands; %0d mismatches.",
			sb.byte_cnt, sb.tile_cnt, sb.led_cnt, sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
